FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the camera frame update block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define CFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check through reset as well
`define CFU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cfu_pkg.sv
// ----------------------------------------------------------------------------
// Camera frame update package
// Types, codes and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package cfu_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CD_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam logic [4:0] CD_LAST = 5'(CD_N - 1);
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST = 5'd14;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] CMD_SLIDE = 3'd0;
  localparam logic [2:0] CMD_ROLL  = 3'd1;
  localparam logic [2:0] CMD_ROT_U = 3'd2;
  localparam logic [2:0] CMD_ROT_V = 3'd3;
  localparam logic [2:0] CMD_SET   = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ACC, S_WR, S_CD_INIT, S_CD_STEP, S_CD_FIN, S_SET_NORM,
    S_SET_ZERO, S_SQRT_INIT, S_SQRT_STEP, S_DIV_INIT, S_DIV_STEP, S_DIV_WR,
    S_RIGHT, S_EMIT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_ACC, OP_WR, OP_CD_INIT, OP_CD_STEP, OP_CD_FIN,
    OP_NORM, OP_ZERO, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP,
    OP_DIV_WR, OP_RIGHT, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {MODE_SLIDE, MODE_TURN, MODE_SQ, MODE_UP} mode_t;

  typedef enum logic [2:0] {WR_EYE, WR_TMP, WR_PAIR, WR_UPX, WR_UPY, WR_UPZ} wr_t;

  typedef struct packed {
    op_t        op;
    mode_t      mode;
    wr_t        wr;
    logic [1:0] k;
    logic [1:0] j;
    logic [4:0] i;
    logic       first;
    logic       sub;
  } ctl_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic pos_zero;
    logic out_free;
  } dp_stat_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/cfu_if.sv
// ----------------------------------------------------------------------------
// Camera frame update channels
// Valid/ready channels for command words and frame words.
// ----------------------------------------------------------------------------
interface cfu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [15:0] turn_angle;
  modport source (output valid, command, coord_x, coord_y, coord_z, turn_angle,
                  input ready);
  modport sink (input valid, command, coord_x, coord_y, coord_z, turn_angle,
                output ready);
endinterface

interface cfu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] upward_x;
  logic signed [15:0] upward_y;
  logic signed [15:0] upward_z;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  modport source (output valid, eye_x, eye_y, eye_z, right_x, right_y, right_z,
                  upward_x, upward_y, upward_z, view_x, view_y, view_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, right_x, right_y, right_z,
                upward_x, upward_y, upward_z, view_x, view_y, view_z,
                output ready);
endinterface

FILE: hdl/cfu_dp.sv
// ----------------------------------------------------------------------------
// Camera frame update datapath
// Frame state, shared multiplier and accumulator, CORDIC, square root,
// divider and the output word register.
// ----------------------------------------------------------------------------
module cfu_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cfu_pkg::ctl_cmd_t  cmd,
  output cfu_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [15:0] in_angle,
  cfu_out_if.source          out_ch
);
  import cfu_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'sd32767) r = 16'sh7fff;
    else if (v < -66'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic [2:0]         cmd_r;
  logic signed [31:0] c_r [3];
  logic signed [15:0] ang_r;
  logic signed [31:0] eye_r [3];
  logic signed [15:0] u_r [3];
  logic signed [15:0] v_r [3];
  logic signed [15:0] n_r [3];
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [15:0] tmp_r;
  logic signed [33:0] cx_r;
  logic signed [33:0] cy_r;
  logic signed [32:0] cr_r;
  logic [1:0]         q_r;
  logic signed [17:0] cs_r;
  logic signed [17:0] sn_r;
  logic [31:0]        mag_r [3];
  logic [63:0]        sv_r;
  logic [63:0]        res_r;
  logic [63:0]        one_r;
  logic [46:0]        rem_r;
  logic [45:0]        dvs_r;
  logic [14:0]        quo_r;
  logic               out_valid_r;
  logic signed [31:0] o_eye_r [3];
  logic signed [15:0] o_u_r [3];
  logic signed [15:0] o_v_r [3];
  logic signed [15:0] o_n_r [3];

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [15:0] pa;
  logic signed [15:0] pb;
  logic signed [65:0] r14;
  logic signed [33:0] cd_dx;
  logic signed [33:0] cd_dy;
  logic signed [32:0] cd_at;
  logic [31:0]        cd_z;
  logic [1:0]         cd_q;
  logic signed [31:0] cd_r;
  logic signed [33:0] fin_c;
  logic signed [33:0] fin_s;
  logic signed [33:0] rc;
  logic signed [33:0] rs;
  logic [64:0]        sq_try;
  logic [31:0]        len;

  assign stat.norm_done = |{mag_r[0][31:30], mag_r[1][31:30], mag_r[2][31:30]};
  assign stat.pos_zero  = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    unique case (cmd_r)
      CMD_ROLL: begin
        pa = u_r[cmd.k];
        pb = v_r[cmd.k];
      end
      CMD_ROT_U: begin
        pa = v_r[cmd.k];
        pb = n_r[cmd.k];
      end
      default: begin
        pa = u_r[cmd.k];
        pb = n_r[cmd.k];
      end
    endcase
    ma = '0;
    mb = '0;
    unique case (cmd.mode)
      MODE_SLIDE: begin
        unique case (cmd.j)
          2'd0: begin
            ma = 33'(c_r[0]);
            mb = 33'(u_r[cmd.k]);
          end
          2'd1: begin
            ma = 33'(c_r[1]);
            mb = 33'(v_r[cmd.k]);
          end
          default: begin
            ma = 33'(c_r[2]);
            mb = 33'(n_r[cmd.k]);
          end
        endcase
      end
      MODE_TURN: begin
        unique case (cmd.j)
          2'd0: begin
            ma = 33'(cs_r);
            mb = 33'(pa);
          end
          2'd1: begin
            ma = 33'(sn_r);
            mb = 33'(pb);
          end
          2'd2: begin
            ma = 33'(cs_r);
            mb = 33'(pb);
          end
          default: begin
            ma = 33'(sn_r);
            mb = 33'(pa);
          end
        endcase
      end
      MODE_SQ: begin
        unique case (cmd.j)
          2'd0: ma = $signed({1'b0, mag_r[0]});
          2'd1: ma = $signed({1'b0, mag_r[1]});
          default: ma = $signed({1'b0, mag_r[2]});
        endcase
        mb = ma;
      end
      default: begin
        unique case (cmd.j)
          2'd0: begin
            ma = 33'(n_r[0]);
            mb = 33'(n_r[1]);
          end
          2'd1: begin
            ma = 33'(n_r[0]);
            mb = 33'(n_r[0]);
          end
          2'd2: begin
            ma = 33'(n_r[2]);
            mb = 33'(n_r[2]);
          end
          default: begin
            ma = 33'(n_r[1]);
            mb = 33'(n_r[2]);
          end
        endcase
      end
    endcase
  end

  assign r14 = (acc_r + 66'sd8192) >>> 14;

  assign cd_z  = {ang_r, 16'h0000};
  assign cd_q  = cd_z[31:30] + {1'b0, cd_z[29]};
  assign cd_r  = $signed(cd_z - {cd_q, 30'h0});
  assign cd_dx = cy_r >>> cmd.i;
  assign cd_dy = cx_r >>> cmd.i;
  assign cd_at = $signed({3'b000, atan_lut(cmd.i)});

  always_comb begin
    unique case (q_r)
      2'd0: begin
        fin_c = cx_r;
        fin_s = cy_r;
      end
      2'd1: begin
        fin_c = -cy_r;
        fin_s = cx_r;
      end
      2'd2: begin
        fin_c = -cx_r;
        fin_s = -cy_r;
      end
      default: begin
        fin_c = cy_r;
        fin_s = -cx_r;
      end
    endcase
  end

  assign rc     = (fin_c + 34'sd32768) >>> 16;
  assign rs     = (fin_s + 34'sd32768) >>> 16;
  assign sq_try = {1'b0, res_r} + {1'b0, one_r};
  assign len    = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r[0]    <= '0;
      eye_r[1]    <= 32'sd32768000;
      eye_r[2]    <= '0;
      u_r[0]      <= '0;
      u_r[1]      <= '0;
      u_r[2]      <= '0;
      v_r[0]      <= '0;
      v_r[1]      <= '0;
      v_r[2]      <= '0;
      n_r[0]      <= '0;
      n_r[1]      <= 16'sd16384;
      n_r[2]      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          cmd_r  <= in_command;
          c_r[0] <= in_x;
          c_r[1] <= in_y;
          c_r[2] <= in_z;
          ang_r  <= in_angle;
          mag_r[0] <= in_x[31] ? 32'(-33'(in_x)) : 32'(in_x);
          mag_r[1] <= in_y[31] ? 32'(-33'(in_y)) : 32'(in_y);
          mag_r[2] <= in_z[31] ? 32'(-33'(in_z)) : 32'(in_z);
          if (in_command == CMD_SET) begin
            eye_r[0] <= in_x;
            eye_r[1] <= in_y;
            eye_r[2] <= in_z;
          end
        end
        OP_MUL: prod_r <= ma * mb;
        OP_ACC: acc_r <= (cmd.first ? 66'sd0 : acc_r) + (cmd.sub ? -prod_r : prod_r);
        OP_WR: begin
          unique case (cmd.wr)
            WR_EYE: eye_r[cmd.k] <= sat32(66'(eye_r[cmd.k]) + r14);
            WR_TMP: tmp_r <= sat16(r14);
            WR_PAIR: begin
              unique case (cmd_r)
                CMD_ROLL: begin
                  u_r[cmd.k] <= tmp_r;
                  v_r[cmd.k] <= sat16(r14);
                end
                CMD_ROT_U: begin
                  v_r[cmd.k] <= tmp_r;
                  n_r[cmd.k] <= sat16(r14);
                end
                default: begin
                  u_r[cmd.k] <= tmp_r;
                  n_r[cmd.k] <= sat16(r14);
                end
              endcase
            end
            WR_UPX: v_r[0] <= sat16(r14);
            WR_UPY: v_r[1] <= sat16(r14);
            default: v_r[2] <= sat16(r14);
          endcase
        end
        OP_CD_INIT: begin
          cx_r <= CORDIC_GAIN;
          cy_r <= '0;
          cr_r <= 33'(cd_r);
          q_r  <= cd_q;
        end
        OP_CD_STEP: begin
          if (!cr_r[32]) begin
            cx_r <= cx_r - cd_dx;
            cy_r <= cy_r + cd_dy;
            cr_r <= cr_r - cd_at;
          end else begin
            cx_r <= cx_r + cd_dx;
            cy_r <= cy_r - cd_dy;
            cr_r <= cr_r + cd_at;
          end
        end
        OP_CD_FIN: begin
          cs_r <= rc[17:0];
          sn_r <= (cmd_r == CMD_ROLL) ? -rs[17:0] : rs[17:0];
        end
        OP_NORM: begin
          mag_r[0] <= {mag_r[0][30:0], 1'b0};
          mag_r[1] <= {mag_r[1][30:0], 1'b0};
          mag_r[2] <= {mag_r[2][30:0], 1'b0};
        end
        OP_ZERO: begin
          u_r[0] <= '0;
          u_r[1] <= '0;
          u_r[2] <= '0;
          v_r[0] <= '0;
          v_r[1] <= '0;
          v_r[2] <= '0;
          n_r[0] <= '0;
          n_r[1] <= '0;
          n_r[2] <= '0;
        end
        OP_SQRT_INIT: begin
          sv_r  <= acc_r[63:0];
          res_r <= '0;
          one_r <= 64'h4000_0000_0000_0000;
        end
        OP_SQRT_STEP: begin
          if ({1'b0, sv_r} >= sq_try) begin
            sv_r  <= sv_r - sq_try[63:0];
            res_r <= (res_r >> 1) + one_r;
          end else begin
            res_r <= res_r >> 1;
          end
          one_r <= one_r >> 2;
        end
        OP_DIV_INIT: begin
          rem_r <= {1'b0, mag_r[cmd.k], 14'h0000} + {16'h0000, len[31:1]};
          dvs_r <= {len, 14'h0000};
          quo_r <= '0;
        end
        OP_DIV_STEP: begin
          if (rem_r >= {1'b0, dvs_r}) begin
            rem_r <= rem_r - {1'b0, dvs_r};
            quo_r <= {quo_r[13:0], 1'b1};
          end else begin
            quo_r <= {quo_r[13:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
        end
        OP_DIV_WR: begin
          n_r[cmd.k] <= c_r[cmd.k][31] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
        end
        OP_RIGHT: begin
          u_r[0] <= n_r[2];
          u_r[1] <= '0;
          u_r[2] <= -n_r[0];
        end
        OP_EMIT: begin
          for (int m = 0; m < 3; m++) begin
            o_eye_r[m] <= eye_r[m];
            o_u_r[m]   <= u_r[m];
            o_v_r[m]   <= v_r[m];
            o_n_r[m]   <= n_r[m];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.eye_x    = o_eye_r[0];
  assign out_ch.eye_y    = o_eye_r[1];
  assign out_ch.eye_z    = o_eye_r[2];
  assign out_ch.right_x  = o_u_r[0];
  assign out_ch.right_y  = o_u_r[1];
  assign out_ch.right_z  = o_u_r[2];
  assign out_ch.upward_x = o_v_r[0];
  assign out_ch.upward_y = o_v_r[1];
  assign out_ch.upward_z = o_v_r[2];
  assign out_ch.view_x   = o_n_r[0];
  assign out_ch.view_y   = o_n_r[1];
  assign out_ch.view_z   = o_n_r[2];

endmodule

FILE: hdl/cfu_ctrl.sv
// ----------------------------------------------------------------------------
// Camera frame update controller
// Sequences each command word through the datapath operations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_command,
  output logic              in_ready,
  input  cfu_pkg::dp_stat_t stat,
  output cfu_pkg::ctl_cmd_t cmd
);
  import cfu_pkg::*;

  ctl_state_t state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] j_r, j_nxt;
  logic [4:0] i_r, i_nxt;
  wr_t        wr_sel;
  logic       first_sel;
  logic       sub_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_SLIDE;
      k_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_SLIDE: begin
        wr_sel    = WR_EYE;
        first_sel = (j_r == 2'd0);
        sub_sel   = 1'b0;
      end
      MODE_TURN: begin
        wr_sel    = (j_r == 2'd1) ? WR_TMP : WR_PAIR;
        first_sel = (j_r == 2'd0) || (j_r == 2'd2);
        sub_sel   = (j_r == 2'd3);
      end
      MODE_SQ: begin
        wr_sel    = WR_EYE;
        first_sel = (j_r == 2'd0);
        sub_sel   = 1'b0;
      end
      default: begin
        wr_sel    = (j_r == 2'd0) ? WR_UPX : ((j_r == 2'd2) ? WR_UPY : WR_UPZ);
        first_sel = (j_r != 2'd2);
        sub_sel   = (j_r == 2'd0) || (j_r == 2'd3);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    in_ready  = 1'b0;
    cmd       = '{op: OP_NONE, mode: mode_r, wr: wr_sel, k: k_r, j: j_r, i: i_r,
                  first: first_sel, sub: sub_sel};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        k_nxt = '0;
        j_nxt = '0;
        i_nxt = '0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          unique case (in_command)
            CMD_SLIDE: begin
              mode_nxt  = MODE_SLIDE;
              state_nxt = S_MUL;
            end
            CMD_ROLL, CMD_ROT_U, CMD_ROT_V: state_nxt = S_CD_INIT;
            CMD_SET: state_nxt = S_SET_NORM;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_MUL;
        j_nxt     = j_r + 2'd1;
        unique case (mode_r)
          MODE_SLIDE: if (j_r == 2'd2) state_nxt = S_WR;
          MODE_TURN: if (j_r == 2'd1 || j_r == 2'd3) state_nxt = S_WR;
          MODE_SQ: if (j_r == 2'd2) state_nxt = S_SQRT_INIT;
          default: if (j_r != 2'd1) state_nxt = S_WR;
        endcase
        if (state_nxt != S_MUL) j_nxt = j_r;
      end
      S_WR: begin
        cmd.op    = OP_WR;
        state_nxt = S_MUL;
        j_nxt     = j_r + 2'd1;
        if (wr_sel == WR_EYE || wr_sel == WR_PAIR) begin
          j_nxt = '0;
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd2) state_nxt = S_EMIT;
        end else if (wr_sel == WR_UPZ) begin
          state_nxt = S_EMIT;
        end
      end
      S_CD_INIT: begin
        cmd.op    = OP_CD_INIT;
        i_nxt     = '0;
        state_nxt = S_CD_STEP;
      end
      S_CD_STEP: begin
        cmd.op = OP_CD_STEP;
        i_nxt  = i_r + 5'd1;
        if (i_r == CD_LAST) state_nxt = S_CD_FIN;
      end
      S_CD_FIN: begin
        cmd.op    = OP_CD_FIN;
        mode_nxt  = MODE_TURN;
        k_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_MUL;
      end
      S_SET_NORM: begin
        if (stat.pos_zero) begin
          state_nxt = S_SET_ZERO;
        end else if (stat.norm_done) begin
          mode_nxt  = MODE_SQ;
          j_nxt     = '0;
          state_nxt = S_MUL;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SET_ZERO: begin
        cmd.op    = OP_ZERO;
        state_nxt = S_EMIT;
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        i_nxt     = '0;
        state_nxt = S_SQRT_STEP;
      end
      S_SQRT_STEP: begin
        cmd.op = OP_SQRT_STEP;
        i_nxt  = i_r + 5'd1;
        if (i_r == SQRT_LAST) begin
          k_nxt     = '0;
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        i_nxt     = '0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        i_nxt  = i_r + 5'd1;
        if (i_r == DIV_LAST) state_nxt = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd.op    = OP_DIV_WR;
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd2) ? S_RIGHT : S_DIV_INIT;
      end
      S_RIGHT: begin
        cmd.op    = OP_RIGHT;
        mode_nxt  = MODE_UP;
        k_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_MUL;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `CFU_ASSERT_RST(a_reset_to_idle, !rst_n |=> (state_r == S_IDLE), "no idle after reset")
  `CFU_ASSERT(a_accept_busy, (in_valid && in_ready) |=> (state_r != S_IDLE), "accept ignored")
  `CFU_ASSERT(a_emit_room, (cmd.op == OP_EMIT) |-> stat.out_free, "emit over held word")
  `CFU_ASSERT(a_div_bound, (state_r == S_DIV_STEP) |-> (i_r <= DIV_LAST), "divider overrun")

endmodule

FILE: hdl/camera_frame_update_top.sv
// ----------------------------------------------------------------------------
// Camera frame update top level
// uvn camera: slide, roll, pitch, yaw and set position, one frame word per
// command word.
//
//   channel  dir  word
//   in_ch    in   command, coord_x/y/z, turn_angle
//   out_ch   out  eye_x/y/z, right_x/y/z, upward_x/y/z, view_x/y/z
//
// One command word at a time; the shared multiplier and iteration counters
// set the time. A turn runs the CORDIC one step per cycle, a set runs a
// normalize shift, a 32-step square root and a 15-step divide per axis.
// Unknown codes go straight to emit. Reset is synchronous; a new word is
// taken while the output word waits.
// ----------------------------------------------------------------------------
module camera_frame_update_top (
  input  logic    clk,
  input  logic    rst_n,
  cfu_in_if.sink  in_ch,
  cfu_out_if.source out_ch
);
  import cfu_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  cfu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cfu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_ch.command),
    .in_x       (in_ch.coord_x),
    .in_y       (in_ch.coord_y),
    .in_z       (in_ch.coord_z),
    .in_angle   (in_ch.turn_angle),
    .out_ch     (out_ch)
  );

endmodule
